// ===== src/krd_pkg.sv =====
// Package for the KISS response deframer.
// Holds the KISS framing codes, body constants and the controller/datapath structs.
// No dependencies; the other files that use it refer to it by scoped names.
package krd_pkg;

    // KISS framing characters.
    localparam logic [7:0] FEND  = 8'hC0;
    localparam logic [7:0] FESC  = 8'hDB;
    localparam logic [7:0] TFEND = 8'hDC;
    localparam logic [7:0] TFESC = 8'hDD;

    // Smallest frame that carries a message, and the fixed second body byte.
    localparam int unsigned MIN_STORED = 6;
    localparam logic [7:0]  BODY_MARK  = 8'd6;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;   // an input request is accepted this cycle
        logic rd;     // read the frame store for the current body byte
        logic load;   // load the current body byte into the output register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic close_ok;  // the byte on the input closes a frame long enough to emit
        logic last;      // the current body byte is the final one of the message
        logic out_free;  // the output register can take a new request this cycle
    } t_dp_status;

endpackage

// ===== src/krd_if.sv =====
// Valid/ready channel interfaces of the KISS response deframer.
// krd_rx_if carries received serial bytes, krd_body_if carries decoded body bytes.
// Depends on nothing.
interface krd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface krd_body_if;
    logic       valid;
    logic       ready;
    logic [7:0] body_byte;
    logic [7:0] message_id;
    logic [4:0] body_length;
    logic       last;

    modport source (output valid, output body_byte, output message_id,
                    output body_length, output last, input ready);
    modport sink   (input valid, input body_byte, input message_id,
                    input body_length, input last, output ready);
endinterface

// ===== src/krd_ctrl.sv =====
// Controller of the KISS response deframer: receive, then read/load per body byte.
// Depends on krd_pkg for the command and status structs.
module krd_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_rx_valid,
    output logic                o_rx_ready,
    input  krd_pkg::t_dp_status i_status,
    output krd_pkg::t_dp_cmd    o_cmd
);

    localparam logic [1:0] S_RECV = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_LOAD = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       take;

    // Input requests are taken only while no message is being emitted.
    assign o_rx_ready = (r_state == S_RECV);
    assign take       = i_rx_valid && o_rx_ready;

    // Commands to the datapath.
    always_comb begin
        o_cmd.take = take;
        o_cmd.rd   = (r_state == S_READ);
        o_cmd.load = (r_state == S_LOAD) && i_status.out_free;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_RECV: begin
                if (take && i_status.close_ok) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                if (i_status.out_free) begin
                    n_state = i_status.last ? S_RECV : S_READ;
                end
            end
            default: begin
                n_state = S_RECV;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RECV;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== src/krd_datapath.sv =====
// Datapath of the KISS response deframer: unescaping, frame store and output register.
// Depends on krd_pkg for framing codes and the command and status structs.
module krd_datapath #(
    parameter int FRAME_DEPTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [7:0]          i_rx_byte,
    input  krd_pkg::t_dp_cmd    i_cmd,
    output krd_pkg::t_dp_status o_status,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic [7:0]          o_body_byte,
    output logic [7:0]          o_message_id,
    output logic [4:0]          o_body_length,
    output logic                o_last
);

    localparam int AW = $clog2(FRAME_DEPTH);
    localparam int CW = $clog2(FRAME_DEPTH + 1);
    localparam int LW = (CW > 5) ? CW : 5;

    // Frame receive state.
    logic          r_in_frame, n_in_frame;
    logic          r_esc,      n_esc;
    logic [CW-1:0] r_fill,     n_fill;

    // Frame store and the two header bytes kept aside.
    logic [7:0]    r_mem [FRAME_DEPTH];
    logic [7:0]    r_type;
    logic [7:0]    r_id;
    logic [7:0]    r_rd;

    // Emission state.
    logic [CW-1:0] r_k;
    logic          r_out_valid, n_out_valid;
    logic [7:0]    r_out_byte;
    logic [7:0]    r_out_id;
    logic [4:0]    r_out_len;
    logic          r_out_last;

    logic          is_fend;
    logic          is_fesc;
    logic [7:0]    dec_byte;
    logic          store_en;
    logic          has_room;
    logic [CW-1:0] rd_sum;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [CW:0]   k_end;
    logic [LW-1:0] len_wide;

    assign is_fend  = (i_rx_byte == krd_pkg::FEND);
    assign is_fesc  = (i_rx_byte == krd_pkg::FESC);
    assign has_room = (r_fill < CW'(FRAME_DEPTH));
    assign wr_addr  = r_fill[AW-1:0];

    // Undo the escape on the byte after FESC.
    always_comb begin
        dec_byte = i_rx_byte;
        if (r_esc) begin
            if (i_rx_byte == krd_pkg::TFEND) begin
                dec_byte = krd_pkg::FEND;
            end else if (i_rx_byte == krd_pkg::TFESC) begin
                dec_byte = krd_pkg::FESC;
            end
        end
    end

    // Frame state update on each accepted request.
    always_comb begin
        n_in_frame = r_in_frame;
        n_esc      = r_esc;
        n_fill     = r_fill;
        store_en   = 1'b0;
        if (i_cmd.take) begin
            if (!r_in_frame) begin
                if (is_fend) begin
                    n_in_frame = 1'b1;
                    n_fill     = '0;
                end
            end else if (is_fend) begin
                n_in_frame = 1'b0;
            end else if (is_fesc) begin
                n_esc = 1'b1;
            end else begin
                n_esc = 1'b0;
                if (has_room) begin
                    store_en = 1'b1;
                    n_fill   = r_fill + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_esc      <= 1'b0;
            r_fill     <= '0;
        end else begin
            r_in_frame <= n_in_frame;
            r_esc      <= n_esc;
            r_fill     <= n_fill;
        end
    end

    // Frame store writes; the type and id bytes are also kept in registers.
    always_ff @(posedge i_clk) begin
        if (store_en) begin
            r_mem[wr_addr] <= dec_byte;
            if (r_fill == CW'(0)) begin
                r_type <= dec_byte;
            end
            if (r_fill == CW'(1)) begin
                r_id <= dec_byte;
            end
        end
    end

    // Body byte k (from two on) comes from stored byte k + 2.
    assign rd_sum  = r_k + CW'(2);
    assign rd_addr = rd_sum[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    // Body byte counter: cleared by every request, advanced on each load.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= '0;
        end else if (i_cmd.take) begin
            r_k <= '0;
        end else if (i_cmd.load) begin
            r_k <= r_k + CW'(1);
        end
    end

    // The body holds fill - 2 bytes, so byte k is the last when k + 3 equals fill.
    assign k_end    = {1'b0, r_k} + (CW + 1)'(3);
    assign len_wide = LW'(r_fill) - LW'(2);

    // Output register.
    assign n_out_valid = i_cmd.load ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            if (r_k == CW'(0)) begin
                r_out_byte <= r_type;
            end else if (r_k == CW'(1)) begin
                r_out_byte <= krd_pkg::BODY_MARK;
            end else begin
                r_out_byte <= r_rd;
            end
            r_out_id   <= r_id;
            r_out_len  <= len_wide[4:0];
            r_out_last <= o_status.last;
        end
    end

    // Status to the controller.
    always_comb begin
        o_status.close_ok = r_in_frame && is_fend && (r_fill >= CW'(krd_pkg::MIN_STORED));
        o_status.last     = (k_end == {1'b0, r_fill});
        o_status.out_free = !r_out_valid || i_out_ready;
    end

    assign o_out_valid   = r_out_valid;
    assign o_body_byte   = r_out_byte;
    assign o_message_id  = r_out_id;
    assign o_body_length = r_out_len;
    assign o_last        = r_out_last;

endmodule

// ===== src/kiss_response_deframer.sv =====
// Top level of the KISS response deframer: controller plus datapath.
// Depends on krd_pkg, krd_if (krd_rx_if, krd_body_if), krd_ctrl and krd_datapath.
//
//   Channel  Dir  Carries                                      Handshake
//   i_rx     in   rx_byte, one received serial byte            valid/ready
//   o_body   out  body_byte, message_id, body_length, last     valid/ready
//
// A byte that does not close a frame is taken back to back.
// A closing FEND of a frame with n stored bytes (n >= 6) starts the emission of
// n - 2 body bytes, each by a frame store read and then an output load, while
// no input request is taken; the output register can then stall the emission.
// Synchronous active-low reset clears the frame state and the output valid;
// the frame store needs no clearing since only bytes of the current frame are read.
module kiss_response_deframer #(
    parameter int FRAME_DEPTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    krd_rx_if.sink     i_rx,
    krd_body_if.source o_body
);

    krd_pkg::t_dp_cmd    cmd;
    krd_pkg::t_dp_status status;

    krd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx.valid),
        .o_rx_ready (i_rx.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    krd_datapath #(
        .FRAME_DEPTH (FRAME_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rx_byte     (i_rx.rx_byte),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_out_ready   (o_body.ready),
        .o_out_valid   (o_body.valid),
        .o_body_byte   (o_body.body_byte),
        .o_message_id  (o_body.message_id),
        .o_body_length (o_body.body_length),
        .o_last        (o_body.last)
    );

endmodule

// ===== src/krd_checker.sv =====
// Port-level checker for the KISS response deframer, bound to the top level.
// Depends only on the top level's ports.
module krd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_rx_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_body_byte,
    input logic [7:0] i_message_id,
    input logic [4:0] i_body_length,
    input logic       i_last
);

    // A stalled result request keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_body_byte) && $stable(i_message_id)
             && $stable(i_body_length) && $stable(i_last)))
        else $error("result payload changed while stalled");

    // No new serial byte is taken while a message is only partly delivered.
    a_no_rx_mid_msg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_last) |-> !i_rx_ready)
        else $error("input ready in the middle of a message");

    // Id and length stay the same over all bytes of one message.
    a_msg_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && !i_last) |=>
            ($stable(i_message_id) && $stable(i_body_length)))
        else $error("message id or length changed within a message");

    // Reset leaves no result pending.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind kiss_response_deframer krd_checker u_krd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_rx_ready    (i_rx.ready),
    .i_out_valid   (o_body.valid),
    .i_out_ready   (o_body.ready),
    .i_body_byte   (o_body.body_byte),
    .i_message_id  (o_body.message_id),
    .i_body_length (o_body.body_length),
    .i_last        (o_body.last)
);

// ===== bench/kiss_response_deframer_test.sv =====
`timescale 1ns / 100ps
// Testbench for kiss_response_deframer: sends serial bytes as KISS frames and checks the
// decoded body bytes against a built-in deframing predictor. Depends on krd_pkg and on the
// krd_rx_if and krd_body_if interfaces.
module kiss_response_deframer_test;

    localparam int          FRAME_DEPTH  = 32;
    localparam int          ITEMS_TARGET = 260;
    localparam int          BUSY_PCT     = 78;
    localparam int          BOTH_PCT     = 34;
    localparam int          DRAIN_CYCLES = 80;

    // One expected request on the body channel.
    typedef struct packed {
        logic [7:0] body_byte;
        logic [7:0] message_id;
        logic [4:0] body_length;
        logic       last;
    } t_body_res;

    // One row of serial stimulus. A typed row carries its own expectation: either
    // no body at all, or the four-byte body of a minimal frame.
    typedef struct packed {
        logic [7:0]  rx_byte;
        logic        typed;
        logic        has_body;
        logic [31:0] body4;
        logic [7:0]  id;
        logic [4:0]  len;
    } t_rx_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    krd_rx_if   rx_ch ();
    krd_body_if body_ch ();

    kiss_response_deframer #(.FRAME_DEPTH(FRAME_DEPTH)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_ch),
        .o_body  (body_ch)
    );

    // Deframer state as the predictor sees it.
    logic        in_frame_m = 1'b0;
    logic        esc_m = 1'b0;
    int unsigned fill_m = 0;
    logic [7:0]  store_m [FRAME_DEPTH];

    t_body_res body_due_q [$];
    t_rx_row   dir_q [$];
    int        n_err = 0;
    int        n_items = 0;
    int        tx_idle_pct = 0;
    int        rx_stall_pct = 0;

    always #5 i_clk = ~i_clk;

    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Decode one serial byte and queue the body bytes that a closing FEND releases.
    function automatic void deframe_byte(input logic [7:0] b);
        logic [7:0] d;
        t_body_res  res;
        int         n;
        int         k;
        d = b;
        if (!in_frame_m) begin
            if (d == krd_pkg::FEND) begin
                in_frame_m = 1'b1;
                fill_m = 0;
            end
            return;
        end
        if (d == krd_pkg::FEND) begin
            in_frame_m = 1'b0;
            if (fill_m < krd_pkg::MIN_STORED) return;
            n = fill_m - 2;
            for (k = 0; k < n; k++) begin
                if (k == 0) res.body_byte = store_m[0];
                else if (k == 1) res.body_byte = krd_pkg::BODY_MARK;
                else res.body_byte = store_m[k + 2];
                res.message_id = store_m[1];
                res.body_length = n[4:0];
                res.last = (k == n - 1);
                body_due_q.push_back(res);
            end
            return;
        end
        if (d == krd_pkg::FESC) begin
            esc_m = 1'b1;
            return;
        end
        if (esc_m) begin
            if (d == krd_pkg::TFEND) d = krd_pkg::FEND;
            else if (d == krd_pkg::TFESC) d = krd_pkg::FESC;
            esc_m = 1'b0;
        end
        if (fill_m < FRAME_DEPTH) begin
            store_m[fill_m] = d;
            fill_m++;
        end
    endfunction

    function automatic t_rx_row plain_row(input logic [7:0] b);
        t_rx_row r;
        r = '0;
        r.rx_byte = b;
        return r;
    endfunction

    // A byte that is known to release nothing.
    function automatic t_rx_row quiet_row(input logic [7:0] b);
        t_rx_row r;
        r = plain_row(b);
        r.typed = 1'b1;
        return r;
    endfunction

    function automatic t_rx_row close_row(input logic [31:0] body4, input logic [7:0] id,
                                          input logic [4:0] len);
        t_rx_row r;
        r = quiet_row(krd_pkg::FEND);
        r.has_body = 1'b1;
        r.body4 = body4;
        r.id = id;
        r.len = len;
        return r;
    endfunction

    function automatic logic [7:0] pick_byte();
        if ($urandom_range(99) < 15) begin
            case ($urandom_range(3))
                0: return krd_pkg::FEND;
                1: return krd_pkg::FESC;
                2: return krd_pkg::TFEND;
                default: return krd_pkg::TFESC;
            endcase
        end
        return 8'($urandom);
    endfunction

    // Present one request on the serial channel and update the predictor once it is taken.
    task automatic send_rx(input t_rx_row r);
        int        base;
        int        k;
        t_body_res res;
        while ($urandom_range(99) < tx_idle_pct) begin
            rx_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        rx_ch.valid = 1'b1;
        rx_ch.rx_byte = r.rx_byte;
        do @(posedge i_clk); while (!rx_ch.ready);
        n_items++;
        base = body_due_q.size();
        deframe_byte(r.rx_byte);
        if (r.typed) begin
            // The typed expectation replaces whatever the predictor queued.
            while (body_due_q.size() > base) res = body_due_q.pop_back();
            if (r.has_body) begin
                for (k = 0; k < 4; k++) begin
                    res.body_byte = r.body4[31 - 8 * k -: 8];
                    res.message_id = r.id;
                    res.body_length = r.len;
                    res.last = (k == 3);
                    body_due_q.push_back(res);
                end
            end
        end
        @(negedge i_clk);
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_rx(plain_row(b));
    endtask

    // Receiver back-pressure, redrawn every cycle.
    initial body_ch.ready = 1'b0;
    always @(negedge i_clk) begin
        body_ch.ready = ($urandom_range(99) >= rx_stall_pct);
    end

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
            n_err++;
        end
    endtask

    // Compare each body request with the oldest expectation.
    always @(posedge i_clk) begin
        t_body_res exp_r;
        if (i_rst_n && body_ch.valid && body_ch.ready) begin
            if (body_due_q.size() == 0) begin
                $display("%0t: unexpected body byte, expected none, got %0h",
                         $time, body_ch.body_byte);
                n_err++;
            end else begin
                exp_r = body_due_q.pop_front();
                check_field("body_byte", exp_r.body_byte, body_ch.body_byte);
                check_field("message_id", exp_r.message_id, body_ch.message_id);
                check_field("body_length", exp_r.body_length, body_ch.body_length);
                check_field("last", exp_r.last, body_ch.last);
            end
        end
    end

    initial begin
        int         n;
        int         k;
        int         sel;
        logic [7:0] v;
        rx_ch.valid = 1'b0;
        rx_ch.rx_byte = 8'h00;

        // Bytes outside a frame are ignored, FESC included.
        dir_q.push_back(quiet_row(8'hFF));
        dir_q.push_back(quiet_row(krd_pkg::FESC));
        // Minimal frame with both escapes and a repeated FESC.
        dir_q.push_back(quiet_row(krd_pkg::FEND));
        dir_q.push_back(plain_row(8'h00));
        dir_q.push_back(plain_row(8'hFF));
        dir_q.push_back(plain_row(8'h11));
        dir_q.push_back(plain_row(8'h22));
        dir_q.push_back(plain_row(krd_pkg::FESC));
        dir_q.push_back(plain_row(krd_pkg::TFEND));
        dir_q.push_back(plain_row(krd_pkg::FESC));
        dir_q.push_back(plain_row(krd_pkg::FESC));
        dir_q.push_back(plain_row(krd_pkg::TFESC));
        dir_q.push_back(close_row({8'h00, krd_pkg::BODY_MARK, krd_pkg::FEND, krd_pkg::FESC},
                                  8'hFF, 5'd4));
        // Short frame that ends with a pending escape.
        dir_q.push_back(quiet_row(krd_pkg::FEND));
        dir_q.push_back(plain_row(8'h55));
        dir_q.push_back(plain_row(krd_pkg::FESC));
        dir_q.push_back(quiet_row(krd_pkg::FEND));
        // The carried escape turns the first byte of the next frame into FEND.
        dir_q.push_back(quiet_row(krd_pkg::FEND));
        dir_q.push_back(plain_row(krd_pkg::TFEND));
        dir_q.push_back(plain_row(8'h80));
        dir_q.push_back(plain_row(8'h01));
        dir_q.push_back(plain_row(8'h02));
        dir_q.push_back(plain_row(8'h3C));
        dir_q.push_back(plain_row(8'h7E));
        dir_q.push_back(plain_row(8'hA5));
        dir_q.push_back(plain_row(krd_pkg::FEND));

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_q[i]) send_rx(dir_q[i]);

        // Random frames, with noise between them and some broken endings.
        while (n_items < ITEMS_TARGET) begin
            case (n_items * 4 / ITEMS_TARGET)
                0: begin tx_idle_pct = 0; rx_stall_pct = 0; end
                1: begin tx_idle_pct = BUSY_PCT; rx_stall_pct = 0; end
                2: begin tx_idle_pct = 0; rx_stall_pct = BUSY_PCT; end
                default: begin tx_idle_pct = BOTH_PCT; rx_stall_pct = BOTH_PCT; end
            endcase
            if ($urandom_range(99) < 8) begin
                repeat ($urandom_range(1, 3)) begin
                    v = 8'($urandom);
                    if (v == krd_pkg::FEND) v = 8'h00;
                    send_byte(v);
                end
            end else begin
                sel = $urandom_range(99);
                if (sel < 15) n = $urandom_range(0, 5);
                else if (sel < 27) n = $urandom_range(28, 36);
                else n = $urandom_range(6, 14);
                send_byte(krd_pkg::FEND);
                for (k = 0; k < n; k++) begin
                    v = pick_byte();
                    if (v == krd_pkg::FEND) begin
                        send_byte(krd_pkg::FESC);
                        send_byte(krd_pkg::TFEND);
                    end else if (v == krd_pkg::FESC) begin
                        send_byte(krd_pkg::FESC);
                        if ($urandom_range(9) == 0) send_byte(krd_pkg::FESC);
                        send_byte(krd_pkg::TFESC);
                    end else begin
                        // Now and then escape a byte that needs no escaping.
                        if ($urandom_range(19) == 0) send_byte(krd_pkg::FESC);
                        send_byte(v);
                    end
                end
                // A dangling escape is carried into the next frame.
                if ($urandom_range(9) == 0) send_byte(krd_pkg::FESC);
                send_byte(krd_pkg::FEND);
            end
        end
        rx_ch.valid = 1'b0;

        while (body_due_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_err == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
src/krd_pkg.sv
src/krd_if.sv
src/krd_ctrl.sv
src/krd_datapath.sv
src/kiss_response_deframer.sv
src/krd_checker.sv
bench/kiss_response_deframer_test.sv
